// ===== rtl/core/cct_pkg.sv =====
// cct_pkg: command codes, field widths and stream packing for the compare channel timer
// no dependencies; imported by compare_channel_timer_unit
package cct_pkg;

  // payload field widths
  localparam int COMMAND_W = 3;
  localparam int CHANNEL_W = 3;
  localparam int VALUE_W   = 16;
  localparam int COUNT_W   = 16;
  localparam int FIRED_W   = 5;
  localparam int STATUS_W  = 1;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_BITS   = COMMAND_W + CHANNEL_W + VALUE_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = COUNT_W + FIRED_W + STATUS_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // defaults for the top level parameters
  localparam int DEF_NUM_CHANNELS = 5;
  localparam int DEF_COUNT_WIDTH  = 16;

  // command codes
  localparam logic [COMMAND_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [COMMAND_W-1:0] CMD_ARM_ABS = 3'd1;
  localparam logic [COMMAND_W-1:0] CMD_ARM_REL = 3'd2;
  localparam logic [COMMAND_W-1:0] CMD_DISARM  = 3'd3;
  localparam logic [COMMAND_W-1:0] CMD_START   = 3'd4;
  localparam logic [COMMAND_W-1:0] CMD_STOP    = 3'd5;
  localparam logic [COMMAND_W-1:0] CMD_ZERO    = 3'd6;
  localparam logic [COMMAND_W-1:0] CMD_READ    = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CHN = 1'b1;

endpackage

// ===== rtl/core/compare_channel_timer_unit.sv =====
// compare_channel_timer_unit: free-running counter with one-shot compare channels
// depends on cct_pkg for command codes, field widths and stream packing
//
// A COUNT_WIDTH-bit timer driven by a command stream: every input transfer carries one
// command (tick, arm absolute, arm relative, disarm, start, stop, zero, read) and yields
// exactly one output transfer with the count after the command, the mask of channels
// that fired on a tick, and a status bit that flags a channel number at or above
// NUM_CHANNELS (in which case nothing changes). The timer runs out of reset with the
// counter at zero and all channels disarmed. A new command is taken every clock: the
// timer state is updated at the input transfer and the result goes into an output
// register, so one command per cycle is sustained as long as the output side takes
// results; an unread result holds s_tready low only while the output register is full
// and m_tready is low. m_tvalid rises in the cycle after the input transfer. All channel
// compares run in parallel against the incremented count. count carries the low 16 bits
// of the counter, fired_mask carries channels 0 to 4.
module compare_channel_timer_unit #(
  parameter int NUM_CHANNELS = cct_pkg::DEF_NUM_CHANNELS,
  parameter int COUNT_WIDTH  = cct_pkg::DEF_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // fields from bit 0: command[2:0], channel[5:3], value[21:6], zero fill
  input  logic [cct_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // fields from bit 0: count[15:0], fired_mask[20:16], status[21], zero fill
  output logic [cct_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready
);
  import cct_pkg::*;

  localparam logic [CHANNEL_W-1:0] NumChan = CHANNEL_W'(NUM_CHANNELS);

  // timer state
  logic [COUNT_WIDTH-1:0] counter, counter_next;
  logic                   running, running_next;
  logic [COUNT_WIDTH-1:0] compare [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] compare_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] armed, armed_next;

  // output register
  logic [COUNT_W-1:0]  out_count;
  logic [FIRED_W-1:0]  out_fired;
  logic [STATUS_W-1:0] out_status;

  // unpacked input fields
  logic [COMMAND_W-1:0]   command;
  logic [CHANNEL_W-1:0]   channel;
  logic [VALUE_W-1:0]     value;
  logic [COUNT_WIDTH-1:0] value_c;
  logic [COUNT_WIDTH-1:0] counter_inc;

  logic                    in_xfer;
  logic                    chan_cmd;
  logic                    chan_bad;
  logic [NUM_CHANNELS-1:0] fired_next;
  logic [FIRED_W-1:0]      fired_out_next;
  logic [COUNT_W-1:0]      count_out_next;
  logic [FIRED_W-1:0]      armed_low;

  assign command = s_tdata[COMMAND_W-1:0];
  assign channel = s_tdata[COMMAND_W +: CHANNEL_W];
  assign value   = s_tdata[COMMAND_W + CHANNEL_W +: VALUE_W];

  // output register frees up when empty or being drained this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // fit value and count to the counter width
  generate
    if (COUNT_WIDTH >= VALUE_W) begin : g_wide
      assign value_c        = COUNT_WIDTH'(value);
      assign count_out_next = counter_next[COUNT_W-1:0];
    end else begin : g_narrow
      assign value_c        = value[COUNT_WIDTH-1:0];
      assign count_out_next = COUNT_W'(counter_next);
    end
  endgenerate

  assign counter_inc = counter + COUNT_WIDTH'(1);

  assign chan_cmd = (command == CMD_ARM_ABS) || (command == CMD_ARM_REL) ||
                    (command == CMD_DISARM);
  assign chan_bad = chan_cmd && (channel >= NumChan);

  always_comb begin
    counter_next = counter;
    running_next = running;
    armed_next   = armed;
    compare_next = compare;
    fired_next   = '0;
    if (!chan_bad) begin
      case (command)
        CMD_TICK: begin
          if (running) begin
            counter_next = counter_inc;
            // all channels compare against the new count at once
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              if (armed[c] && (compare[c] == counter_inc)) begin
                armed_next[c] = 1'b0;
                fired_next[c] = 1'b1;
              end
            end
          end
        end
        CMD_ARM_ABS: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (channel == CHANNEL_W'(c)) begin
              compare_next[c] = value_c;
              armed_next[c]   = 1'b1;
            end
          end
        end
        CMD_ARM_REL: begin
          // offset from the present count, wrapping
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (channel == CHANNEL_W'(c)) begin
              compare_next[c] = counter + value_c;
              armed_next[c]   = 1'b1;
            end
          end
        end
        CMD_DISARM: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (channel == CHANNEL_W'(c)) begin
              armed_next[c] = 1'b0;
            end
          end
        end
        CMD_START: running_next = 1'b1;
        CMD_STOP:  running_next = 1'b0;
        CMD_ZERO:  counter_next = '0;
        CMD_READ:  ;
        default:   ;
      endcase
    end
  end

  // mask keeps channels 0 to 4, missing channels read as zero
  generate
    for (genvar i = 0; i < FIRED_W; i++) begin : g_mask
      if (i < NUM_CHANNELS) begin : g_have
        assign fired_out_next[i] = fired_next[i];
        assign armed_low[i]      = armed[i];
      end else begin : g_none
        assign fired_out_next[i] = 1'b0;
        assign armed_low[i]      = 1'b0;
      end
    end
  endgenerate

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      counter  <= '0;
      running  <= 1'b1;
      armed    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_xfer) begin
        counter <= counter_next;
        running <= running_next;
        armed   <= armed_next;
      end
      if (in_xfer) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // compare values and result payload, loaded on an input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      compare    <= compare_next;
      out_count  <= count_out_next;
      out_fired  <= fired_out_next;
      out_status <= chan_bad ? STATUS_BAD_CHN : STATUS_OK;
    end
  end

  assign m_tdata = {(OUT_DATA_W - OUT_BITS)'(0), out_status, out_fired, out_count};

`ifndef NO_ASSERTIONS
  // an input transfer always leaves a result behind
  assert property (@(posedge clk) disable iff (rst) in_xfer |=> m_tvalid)
    else $error("result missing after input transfer");

  // a rejected channel number leaves the timer untouched
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && chan_bad) |=> ($stable(counter) && $stable(armed) && $stable(running)))
    else $error("state changed on out-of-range channel");

  // a fired channel is disarmed right after
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> ((out_fired & armed_low) == '0))
    else $error("fired channel still armed");

  // an error result never reports fired channels
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status == STATUS_BAD_CHN)) |-> (out_fired == '0))
    else $error("fired mask set on rejected command");
`endif

endmodule
